// ----- design/ple_pkg.sv -----
package ple_pkg;

    localparam int PLE_CAPACITY = 32;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 6;
    localparam int COUNT_OUT_W  = 6;

    typedef enum logic [2:0] {
        OP_INS_FIRST = 3'd0,
        OP_INS_LAST  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FIRST = 3'd3,
        OP_DEL_LAST  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_READ_AT   = 3'd6,
        OP_UNUSED    = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef struct packed {
        op_t                       operation;
        logic signed [DATA_W-1:0]  value;
        logic        [POS_W-1:0]   position;
    } in_req_t;

    typedef struct packed {
        status_t                    status;
        logic [COUNT_OUT_W-1:0]     element_count;
        logic signed [DATA_W-1:0]   read_value;
    } out_req_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic                      ins;
        logic                      del;
        logic signed [DATA_W-1:0]  word;
    } cell_cmd_t;

endpackage

// ----- design/ple_cell.sv -----
module ple_cell
    import ple_pkg::*;
#(
    parameter int SLOT_W = POS_W,
    parameter int INDEX  = 0
)
(
    input  logic                      clk,
    input  cell_cmd_t                 cmd,
    input  logic [SLOT_W-1:0]         slot,
    input  logic signed [DATA_W-1:0]  prev_data,
    input  logic signed [DATA_W-1:0]  next_data,
    output logic signed [DATA_W-1:0]  data,
    output logic signed [DATA_W-1:0]  rd_data
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     at_slot;
    logic                     past_slot;

    assign at_slot   = (slot == MY_SLOT);
    assign past_slot = (MY_SLOT > slot);

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (at_slot)
                data_next = cmd.word;
            else if (past_slot)
                data_next = prev_data;
        end
        else if (cmd.del)
        begin
            // close the gap: take the neighbor behind
            if (at_slot || past_slot)
                data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = at_slot ? data_reg : '0;

endmodule

// ----- design/positional_list_engine_top.sv -----
// Ordered list of up to CAPACITY signed 32-bit words held in a row of cells.
// Input channel (in_valid / in_ready / in_data): one request names an
// operation - insert first, last or at a one-based position, delete first,
// last or at a position, or read at a position.
// Output channel (out_valid / out_ready / out_data): exactly one result per
// request with status, element count after the operation and read value.
// Result: registered, valid in the cycle after acceptance. Throughput: one
// request per cycle unless stalled. Every cell shifts toward or away from
// its neighbor in the same cycle, so an insert or delete at any position
// completes in the accepting cycle; the output register is the only stage.
// Stall: while a result waits in the output register and out_ready is low,
// in_ready is low and no request is taken; the list holds its contents.
// When out_ready is high the next request is taken in the same cycle the
// waiting result leaves.
// Reset: rst_n clears the element count and drops out_valid; the list is
// empty right after reset and no clearing pass is needed.
module positional_list_engine_top
    import ple_pkg::*;
#(
    parameter int CAPACITY = PLE_CAPACITY
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_req_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output out_req_t out_data
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SLOT_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      out_valid_reg;
    out_req_t                  out_data_reg;
    out_req_t                  result;
    logic                      accept;
    logic                      full;
    logic                      empty;
    logic [SLOT_W-1:0]         pos_w;
    logic [SLOT_W-1:0]         cnt_w;
    logic [SLOT_W-1:0]         slot;
    logic                      do_ins;
    logic                      do_del;
    logic                      do_read;
    status_t                   status;
    cell_cmd_t                 cmd;
    logic signed [DATA_W-1:0]  read_word;
    logic signed [DATA_W-1:0]  cell_q  [CAPACITY];
    logic signed [DATA_W-1:0]  cell_rd [CAPACITY];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign full  = (count_reg == CAP_CNT);
    assign empty = (count_reg == '0);
    assign pos_w = SLOT_W'(in_data.position);
    assign cnt_w = SLOT_W'(count_reg);

    always_comb
    begin
        status  = ST_BADPOS;
        slot    = '0;
        do_ins  = 1'b0;
        do_del  = 1'b0;
        do_read = 1'b0;
        case (in_data.operation)
            OP_INS_FIRST:
            begin
                if (full)
                    status = ST_FULL;
                else
                begin
                    status = ST_DONE;
                    do_ins = 1'b1;
                end
            end
            OP_INS_LAST:
            begin
                if (full)
                    status = ST_FULL;
                else
                begin
                    status = ST_DONE;
                    slot   = cnt_w;
                    do_ins = 1'b1;
                end
            end
            OP_INS_AT:
            begin
                if (full)
                    status = ST_FULL;
                else if (pos_w == '0 || (pos_w - 1'b1) > cnt_w)
                    status = ST_BADPOS;
                else
                begin
                    status = ST_DONE;
                    slot   = pos_w - 1'b1;
                    do_ins = 1'b1;
                end
            end
            OP_DEL_FIRST:
            begin
                if (empty)
                    status = ST_EMPTY;
                else
                begin
                    status = ST_DONE;
                    do_del = 1'b1;
                end
            end
            OP_DEL_LAST:
            begin
                if (empty)
                    status = ST_EMPTY;
                else
                begin
                    status = ST_DONE;
                    slot   = cnt_w - 1'b1;
                    do_del = 1'b1;
                end
            end
            OP_DEL_AT:
            begin
                if (empty)
                    status = ST_EMPTY;
                else if (pos_w == '0 || pos_w > cnt_w)
                    status = ST_BADPOS;
                else
                begin
                    status = ST_DONE;
                    slot   = pos_w - 1'b1;
                    do_del = 1'b1;
                end
            end
            OP_READ_AT:
            begin
                // slot still addresses the read even when out of range
                slot = pos_w - 1'b1;
                if (empty)
                    status = ST_EMPTY;
                else if (pos_w == '0 || pos_w > cnt_w)
                    status = ST_BADPOS;
                else
                begin
                    status  = ST_DONE;
                    do_read = 1'b1;
                end
            end
            default:
            begin
                status = ST_BADPOS;
            end
        endcase
    end

    assign cmd.ins  = accept && do_ins;
    assign cmd.del  = accept && do_del;
    assign cmd.word = in_data.value;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
            count_next = count_reg + 1'b1;
        else if (cmd.del)
            count_next = count_reg - 1'b1;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] prev_d;
        logic signed [DATA_W-1:0] next_d;

        if (i == 0)
        begin : g_first
            assign prev_d = cell_q[i];
        end
        else
        begin : g_prev
            assign prev_d = cell_q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_d = cell_q[i];
        end
        else
        begin : g_next
            assign next_d = cell_q[i+1];
        end

        ple_cell #(
            .SLOT_W (SLOT_W),
            .INDEX  (i)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .slot      (slot),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_q[i]),
            .rd_data   (cell_rd[i])
        );
    end

    // at most one cell matches the slot; the rest drive zero
    always_comb
    begin
        read_word = '0;
        for (int k = 0; k < CAPACITY; k++)
            read_word = read_word | cell_rd[k];
    end

    always_comb
    begin
        result.status        = status;
        result.element_count = COUNT_OUT_W'(count_next);
        result.read_value    = do_read ? read_word : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("element count above capacity");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted request produced no result");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.element_count == COUNT_OUT_W'(count_reg))
        else $error("reported count differs from held count");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == ST_FULL) |-> count_reg == CAP_CNT)
        else $error("full status while list not full");
`endif

endmodule

// ----- sim/list_result_checker.sv -----
`timescale 1ns / 100ps

module list_result_checker
    import ple_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_ready,
    input  in_req_t  in_data,
    input  logic     out_valid,
    input  logic     out_ready,
    input  out_req_t out_data,
    output int       mismatch_count,
    output int       results_pending
);

    logic signed [DATA_W-1:0] list_cells [PLE_CAPACITY];
    int                       list_len;
    out_req_t                 expected_results [$];

    // Apply one request to the list copy and return the result it must give.
    function automatic out_req_t apply_list_op(in_req_t r);
        out_req_t res;
        int       pos;
        int       slot;
        pos            = int'(r.position);
        res.status     = ST_BADPOS;
        res.read_value = '0;
        case (r.operation)
            OP_INS_FIRST, OP_INS_LAST, OP_INS_AT:
            begin
                if (r.operation == OP_INS_FIRST)
                    slot = 0;
                else if (r.operation == OP_INS_LAST)
                    slot = list_len;
                else
                    slot = pos - 1;
                // a full list wins over a bad position
                if (list_len >= PLE_CAPACITY)
                    res.status = ST_FULL;
                else if (slot < 0 || slot > list_len)
                    res.status = ST_BADPOS;
                else
                begin
                    for (int i = list_len; i > slot; i--)
                        list_cells[i] = list_cells[i-1];
                    list_cells[slot] = r.value;
                    list_len++;
                    res.status = ST_DONE;
                end
            end
            OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT:
            begin
                if (r.operation == OP_DEL_FIRST)
                    slot = 0;
                else if (r.operation == OP_DEL_LAST)
                    slot = list_len - 1;
                else
                    slot = pos - 1;
                if (list_len == 0)
                    res.status = ST_EMPTY;
                else if (slot < 0 || slot >= list_len)
                    res.status = ST_BADPOS;
                else
                begin
                    for (int i = slot; i + 1 < list_len; i++)
                        list_cells[i] = list_cells[i+1];
                    list_len--;
                    res.status = ST_DONE;
                end
            end
            OP_READ_AT:
            begin
                if (list_len == 0)
                    res.status = ST_EMPTY;
                else if (pos == 0 || pos > list_len)
                    res.status = ST_BADPOS;
                else
                begin
                    res.read_value = list_cells[pos-1];
                    res.status     = ST_DONE;
                end
            end
            default:
                res.status = ST_BADPOS;
        endcase
        res.element_count = list_len[COUNT_OUT_W-1:0];
        return res;
    endfunction

    always @(posedge clk)
    begin
        out_req_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result: status %0d count %0d read %0d",
                                 out_data.status, out_data.element_count,
                                 $signed(out_data.read_value));
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.status !== want.status
                        || out_data.element_count !== want.element_count
                        || out_data.read_value !== want.read_value)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("result mismatch: status exp %0d got %0d, count exp %0d got %0d",
                                     want.status, out_data.status,
                                     want.element_count, out_data.element_count);
                            $display("    read exp %0d got %0d",
                                     $signed(want.read_value),
                                     $signed(out_data.read_value));
                        end
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_list_op(in_data));
            results_pending = expected_results.size();
        end
        else
        begin
            mismatch_count  = 0;
            results_pending = 0;
            list_len        = 0;
            expected_results.delete();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top
    import ple_pkg::*;
();

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    in_req_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    out_req_t out_data;

    int       mismatches;
    int       pending;
    bit       bulk_started = 1'b0;
    int       burst_left   = 0;

    always #1 clk = ~clk;

    positional_list_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    list_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .mismatch_count  (mismatches),
        .results_pending (pending)
    );

    function automatic in_req_t list_request(op_t op, logic [DATA_W-1:0] word,
                                             int pos);
        in_req_t r;
        r.operation = op;
        r.value     = word;
        r.position  = pos[POS_W-1:0];
        return r;
    endfunction

    // bias 0 grows the list, 1 shrinks it, 2 keeps it roughly level
    function automatic in_req_t random_list_request(int bias);
        int                pick;
        int                ins_pct;
        int                del_pct;
        int                pos;
        logic [DATA_W-1:0] word;
        op_t               op;
        ins_pct = (bias == 0) ? 75 : (bias == 1) ? 15 : 40;
        del_pct = (bias == 0) ? 10 : (bias == 1) ? 70 : 40;
        pick    = $urandom_range(0, 99);
        if (pick < ins_pct)
            op = op_t'($urandom_range(OP_INS_FIRST, OP_INS_AT));
        else if (pick < ins_pct + del_pct)
            op = op_t'($urandom_range(OP_DEL_FIRST, OP_DEL_AT));
        else if (pick < 97)
            op = OP_READ_AT;
        else
            op = OP_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            pos = $urandom_range(1, 8);
        else if (pick < 75)
            pos = $urandom_range(1, PLE_CAPACITY + 1);
        else if (pick < 85)
            pos = 0;
        else
            pos = $urandom_range(0, 63);
        pick = $urandom_range(0, 19);
        if (pick == 0)
            word = 32'h7fff_ffff;
        else if (pick == 1)
            word = 32'h8000_0000;
        else
            word = $urandom;
        return list_request(op, word, pos);
    endfunction

    // Hold valid across requests within a burst; drop it only for a gap.
    task automatic offer_request(input in_req_t r);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 24);
        end
        in_data  <= r;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
    endtask

    initial
    begin : result_sink
        int  mode;
        int  span;
        bit  long_hold_done;
        long_hold_done = 1'b0;
        @(posedge clk);
        forever
        begin
            if (bulk_started && !long_hold_done)
            begin
                // stall the output long enough that the input backs up
                out_ready <= 1'b0;
                repeat (200) @(posedge clk);
                long_hold_done = 1'b1;
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 60);
            for (int k = 0; k < span; k++)
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #500000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int seg_left;
        int bias;
        seg_left = 0;
        bias     = 2;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, bad positions, unused code
        offer_request(list_request(OP_READ_AT,   32'd0, 1));
        offer_request(list_request(OP_DEL_FIRST, 32'd0, 0));
        offer_request(list_request(OP_DEL_LAST,  32'd0, 0));
        offer_request(list_request(OP_DEL_AT,    32'd0, 1));
        offer_request(list_request(OP_INS_AT,    32'd5, 0));
        offer_request(list_request(OP_INS_AT,    32'd6, 2));
        offer_request(list_request(OP_UNUSED,    32'd7, 1));
        // build a short list with extreme values
        offer_request(list_request(OP_INS_FIRST, 32'h7fff_ffff, 0));
        offer_request(list_request(OP_INS_LAST,  32'h8000_0000, 0));
        offer_request(list_request(OP_INS_AT,    32'hffff_ffff, 2));
        offer_request(list_request(OP_INS_AT,    32'd0, 4));
        offer_request(list_request(OP_INS_AT,    32'd9, 63));
        offer_request(list_request(OP_READ_AT,   32'd0, 0));
        for (int p = 1; p <= 5; p++)
            offer_request(list_request(OP_READ_AT, 32'd0, p));
        offer_request(list_request(OP_READ_AT,   32'd0, 63));
        offer_request(list_request(OP_DEL_AT,    32'd0, 0));
        offer_request(list_request(OP_DEL_AT,    32'd0, 5));
        offer_request(list_request(OP_DEL_AT,    32'd0, 2));
        offer_request(list_request(OP_DEL_FIRST, 32'd0, 0));
        offer_request(list_request(OP_DEL_LAST,  32'd0, 0));
        offer_request(list_request(OP_UNUSED,    32'hdead_beef, 63));

        bulk_started = 1'b1;
        for (int n = 0; n < 1450; n++)
        begin
            if (seg_left == 0)
            begin
                bias     = $urandom_range(0, 2);
                seg_left = $urandom_range(20, 80);
            end
            if (n == 725)
            begin
                // let every outstanding result drain before going on
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            offer_request(random_list_request(bias));
            seg_left--;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- positional_list_engine_top.f -----
design/ple_pkg.sv
design/ple_cell.sv
design/positional_list_engine_top.sv
sim/list_result_checker.sv
sim/tb_top.sv
